// ===== src/wcer_pkg.sv =====
// Package: shared constants and types for the window copy escape run expander.
`timescale 1ns / 1ps
package wcer_pkg;

  localparam int unsigned WindowDepth = 8192;  // power of two
  localparam int unsigned MaxResults  = 64;

  localparam logic [7:0] EscOpen = 8'h81;
  localparam logic [7:0] EscRun  = 8'h82;

  localparam logic [1:0] OpLiteral = 2'd0;
  localparam logic [1:0] OpCopy    = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;

  localparam logic [1:0] PhNone = 2'd0;
  localparam logic [1:0] PhOpen = 2'd1;
  localparam logic [1:0] PhRun  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FEED  = 4'b0010,
    ST_EMIT2 = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       finished;
  } res_t;

endpackage

// ===== src/window_copy_escape_run_expander_unit.sv =====
// Top level: history window, escape expander and result buffering.
`timescale 1ns / 1ps
// Takes one literal, copy or restart item at a time. Each history byte of
// a copy needs one read of the window memory read port and each result one
// output transfer, so a byte that yields two results passes through an extra
// state (ST_EMIT2). A restart needs no clearing pass: a fill mark makes
// unwritten history read as zero. Output stalls hold the expander. At most
// 64 results are produced per item; the last one carries last_o.
module window_copy_escape_run_expander_unit #(
  parameter int unsigned WINDOW_DEPTH = wcer_pkg::WindowDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [5:0]  copy_length_i,
  input  logic [12:0] copy_distance_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  repeat_count_o,
  output logic        last_o,
  output logic        finished_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] WpLast = AW'(WINDOW_DEPTH - 1);
  localparam logic [6:0] ResMax = 7'(wcer_pkg::MaxResults);

  logic [7:0] mem [WINDOW_DEPTH];

  wcer_pkg::state_e state_q, state_d;
  logic [31:0]   len_cfg_q;
  logic [31:0]   rem_q, rem_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          full_q, full_d;
  logic [1:0]    phase_q, phase_d;
  logic [7:0]    last_out_q, last_out_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          is_copy_q, is_copy_d;
  logic [7:0]    lit_q, lit_d;
  logic [6:0]    res_cnt_q, res_cnt_d;
  logic          pend_vld_q, pend_vld_d;
  wcer_pkg::res_t pend_q, pend_d;
  logic          e2_fin_q, e2_fin_d;
  logic [7:0]    e2_byte_q, e2_byte_d;
  logic          out_vld_q;
  wcer_pkg::res_t out_q;
  logic          out_last_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata_q, fwd_byte_q;
  logic          fwd_q, rvld_q;

  logic          accept, out_free, go;
  logic          out_load, out_last_d;
  wcer_pkg::res_t out_d;
  logic          em_req;
  wcer_pkg::res_t em;
  logic [15:0]   dist_ext;
  logic [7:0]    c;
  logic [31:0]   rem_m1, rem_m2, rem_mn, n_ext;
  logic [7:0]    n;

  assign in_stall_o = (state_q != wcer_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign go         = out_free || !pend_vld_q;
  assign dist_ext   = {3'b000, copy_distance_i};

  assign c = is_copy_q ? (fwd_q ? fwd_byte_q : (rvld_q ? rdata_q : 8'h00)) : lit_q;
  assign n      = c - 8'd1;
  assign n_ext  = {24'd0, n};
  assign rem_m1 = rem_q - 32'd1;
  assign rem_m2 = rem_q - 32'd2;
  assign rem_mn = rem_q - n_ext;
  assign wdata  = c;

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    wp_d       = wp_q;
    full_d     = full_q;
    phase_d    = phase_q;
    last_out_d = last_out_q;
    rd_d       = rd_q;
    cnt_d      = cnt_q;
    is_copy_d  = is_copy_q;
    lit_d      = lit_q;
    res_cnt_d  = res_cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    e2_fin_d   = e2_fin_q;
    e2_byte_d  = e2_byte_q;
    out_load   = 1'b0;
    out_d      = pend_q;
    out_last_d = 1'b0;
    em_req     = 1'b0;
    em         = '{out_byte: c, repeat_count: 8'd1, finished: 1'b0};
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    raddr      = rd_q;

    case (state_q)
      wcer_pkg::ST_IDLE: begin
        if (accept) begin
          res_cnt_d = '0;
          case (operation_i)
            wcer_pkg::OpLiteral: begin
              lit_d     = literal_byte_i;
              is_copy_d = 1'b0;
              cnt_d     = 6'd1;
              state_d   = wcer_pkg::ST_FEED;
            end
            wcer_pkg::OpCopy: begin
              if (copy_length_i != 6'd0) begin
                raddr     = wp_q - dist_ext[AW-1:0];
                mem_re    = 1'b1;
                rd_d      = raddr + 1'b1;
                cnt_d     = copy_length_i;
                is_copy_d = 1'b1;
                state_d   = wcer_pkg::ST_FEED;
              end
            end
            wcer_pkg::OpRestart: begin
              wp_d       = '0;
              full_d     = 1'b0;
              phase_d    = wcer_pkg::PhNone;
              last_out_d = 8'h00;
              rem_d      = len_cfg_q;
            end
            default: begin
            end
          endcase
        end
      end

      wcer_pkg::ST_FEED: begin
        if (go) begin
          if (rem_q != 32'd0) begin
            mem_we = 1'b1;
            wp_d   = wp_q + 1'b1;
            if (wp_q == WpLast) full_d = 1'b1;
            case (phase_q)
              wcer_pkg::PhOpen: begin
                if (c == wcer_pkg::EscRun) begin
                  phase_d = wcer_pkg::PhRun;
                end else begin
                  em_req      = 1'b1;
                  em.out_byte = wcer_pkg::EscOpen;
                  em.finished = (rem_m1 == 32'd0);
                  rem_d       = rem_m1;
                  last_out_d  = wcer_pkg::EscOpen;
                  if (rem_m1 != 32'd0 && !(c == wcer_pkg::EscOpen && rem_m1 == 32'd1)) begin
                    phase_d    = wcer_pkg::PhNone;
                    last_out_d = c;
                    rem_d      = rem_m2;
                    e2_byte_d  = c;
                    e2_fin_d   = (rem_m2 == 32'd0);
                    state_d    = wcer_pkg::ST_EMIT2;
                  end
                end
              end
              wcer_pkg::PhRun: begin
                phase_d = wcer_pkg::PhNone;
                if (c == 8'h00) begin
                  em_req      = 1'b1;
                  em.out_byte = wcer_pkg::EscOpen;
                  em.finished = (rem_m1 == 32'd0);
                  rem_d       = rem_m1;
                  if (rem_m1 != 32'd0) begin
                    last_out_d = wcer_pkg::EscRun;
                    rem_d      = rem_m2;
                    e2_byte_d  = wcer_pkg::EscRun;
                    e2_fin_d   = (rem_m2 == 32'd0);
                    state_d    = wcer_pkg::ST_EMIT2;
                  end
                end else if (n_ext <= rem_q && n != 8'd0) begin
                  em_req          = 1'b1;
                  em.out_byte     = last_out_q;
                  em.repeat_count = n;
                  em.finished     = (rem_mn == 32'd0);
                  rem_d           = rem_mn;
                end
              end
              default: begin
                if (c == wcer_pkg::EscOpen && rem_q != 32'd1) begin
                  phase_d = wcer_pkg::PhOpen;
                end else begin
                  em_req      = 1'b1;
                  em.finished = (rem_m1 == 32'd0);
                  rem_d       = rem_m1;
                  last_out_d  = c;
                end
              end
            endcase
          end
          if (state_d == wcer_pkg::ST_FEED) begin
            if (cnt_q == 6'd1) begin
              state_d = wcer_pkg::ST_FLUSH;
            end else begin
              mem_re  = 1'b1;
              rd_d    = rd_q + 1'b1;
              cnt_d   = cnt_q - 6'd1;
            end
          end
        end
      end

      wcer_pkg::ST_EMIT2: begin
        if (go) begin
          em_req      = 1'b1;
          em.out_byte = e2_byte_q;
          em.finished = e2_fin_q;
          if (cnt_q == 6'd1) begin
            state_d = wcer_pkg::ST_FLUSH;
          end else begin
            mem_re  = 1'b1;
            rd_d    = rd_q + 1'b1;
            cnt_d   = cnt_q - 6'd1;
            state_d = wcer_pkg::ST_FEED;
          end
        end
      end

      wcer_pkg::ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = wcer_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = wcer_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wcer_pkg::ST_IDLE;
      end
    endcase

    if (em_req && res_cnt_q < ResMax) begin
      res_cnt_d  = res_cnt_q + 7'd1;
      pend_d     = em;
      pend_vld_d = 1'b1;
      if (pend_vld_q) out_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      fwd_q      <= mem_we && (raddr == wp_q);
      fwd_byte_q <= wdata;
      rvld_q     <= full_q || (raddr < wp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wcer_pkg::ST_IDLE;
      len_cfg_q  <= '0;
      rem_q      <= '0;
      wp_q       <= '0;
      full_q     <= 1'b0;
      phase_q    <= wcer_pkg::PhNone;
      last_out_q <= 8'h00;
      rd_q       <= '0;
      cnt_q      <= '0;
      is_copy_q  <= 1'b0;
      res_cnt_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_wr_en_i) len_cfg_q <= cfg_wr_data_i;
      rem_q      <= rem_d;
      wp_q       <= wp_d;
      full_q     <= full_d;
      phase_q    <= phase_d;
      last_out_q <= last_out_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
      is_copy_q  <= is_copy_d;
      res_cnt_q  <= res_cnt_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lit_q     <= lit_d;
    pend_q    <= pend_d;
    e2_fin_q  <= e2_fin_d;
    e2_byte_q <= e2_byte_d;
    if (out_load) begin
      out_q      <= out_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = out_q.out_byte;
  assign repeat_count_o = out_q.repeat_count;
  assign finished_o     = out_q.finished;
  assign last_o         = out_last_q;

endmodule

// ===== verif/tb_window_copy_escape_run_expander_unit.sv =====
// Self-checking bench: literal, copy and restart transfers checked against a predictor.
`timescale 1ns / 1ps
module tb_window_copy_escape_run_expander_unit;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int Predicted = -1;
  localparam int DrainCycles = 200;
  localparam int RandItems = 355;
  localparam int RunLimitNs = 6_000_000;

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] cnt;
    logic       last;
    logic       fin;
  } sym_t;

  typedef struct packed {
    logic        set_cfg;
    logic [31:0] cfg;
    logic [1:0]  op;
    logic [7:0]  lit;
    logic [5:0]  len;
    logic [12:0] back_dist;
    int          n_typed;
    logic [7:0]  t_val;
    logic [7:0]  t_cnt;
    logic        t_fin;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [31:0] cfg_wr_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = wcer_pkg::OpLiteral;
  logic [7:0]  literal_byte_i = '0;
  logic [5:0]  copy_length_i = '0;
  logic [12:0] copy_distance_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic [7:0]  repeat_count_o;
  logic        last_o;
  logic        finished_o;

  // decoder state as the predictor sees it
  logic [7:0]  hist_mem [wcer_pkg::WindowDepth];
  logic [12:0] hist_wp;
  logic [1:0]  esc_phase;
  logic [7:0]  prev_byte;
  logic [31:0] budget_left;
  logic [31:0] zone_len;

  sym_t item_syms[$];
  sym_t decoded_due[$];
  row_t dir_tab[$];

  int fault_count = 0;
  int items_fed = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  window_copy_escape_run_expander_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .literal_byte_i (literal_byte_i),
    .copy_length_i  (copy_length_i),
    .copy_distance_i(copy_distance_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o),
    .finished_o     (finished_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void clear_zone();
    for (int k = 0; k < wcer_pkg::WindowDepth; k++) hist_mem[k] = 8'h00;
    hist_wp = '0;
    esc_phase = wcer_pkg::PhNone;
    prev_byte = 8'h00;
  endfunction

  function automatic void emit_sym(input logic [7:0] v, input logic [7:0] c);
    sym_t s;
    if (item_syms.size() >= wcer_pkg::MaxResults) return;
    s.val = v;
    s.cnt = c;
    s.last = 1'b0;
    s.fin = (budget_left == 32'd0);
    item_syms.insert(item_syms.size(), s);
  endfunction

  function automatic void escape_step(input logic [7:0] c);
    logic [31:0] run_n;
    if (esc_phase == wcer_pkg::PhOpen) begin
      if (c == wcer_pkg::EscRun) begin
        esc_phase = wcer_pkg::PhRun;
        return;
      end
      prev_byte = wcer_pkg::EscOpen;
      budget_left--;
      emit_sym(wcer_pkg::EscOpen, 8'd1);
      if (budget_left == 32'd0) return;
      if (c == wcer_pkg::EscOpen && budget_left == 32'd1) return;
      esc_phase = wcer_pkg::PhNone;
      prev_byte = c;
      budget_left--;
      emit_sym(c, 8'd1);
      return;
    end
    esc_phase = wcer_pkg::PhNone;
    if (c == 8'h00) begin
      budget_left--;
      emit_sym(wcer_pkg::EscOpen, 8'd1);
      if (budget_left == 32'd0) return;
      prev_byte = wcer_pkg::EscRun;
      budget_left--;
      emit_sym(wcer_pkg::EscRun, 8'd1);
      return;
    end
    run_n = {24'd0, c} - 32'd1;
    if (run_n > budget_left) return;
    if (run_n != 32'd0) begin
      budget_left -= run_n;
      emit_sym(prev_byte, run_n[7:0]);
    end
  endfunction

  function automatic void feed_byte(input logic [7:0] c);
    if (budget_left == 32'd0) return;
    hist_mem[hist_wp] = c;
    hist_wp = hist_wp + 13'd1;
    if (esc_phase != wcer_pkg::PhNone) begin
      escape_step(c);
      return;
    end
    if (c == wcer_pkg::EscOpen && budget_left != 32'd1) begin
      esc_phase = wcer_pkg::PhOpen;
      return;
    end
    prev_byte = c;
    budget_left--;
    emit_sym(c, 8'd1);
  endfunction

  function automatic void expand_item(input logic [1:0] op, input logic [7:0] lit,
                                      input logic [5:0] len, input logic [12:0] back_dist);
    logic [12:0] rd;
    item_syms.delete();
    case (op)
      wcer_pkg::OpLiteral: feed_byte(lit);
      wcer_pkg::OpCopy: begin
        rd = hist_wp - back_dist;
        for (int k = 0; k < len; k++) begin
          feed_byte(hist_mem[rd]);
          rd = rd + 13'd1;
        end
      end
      wcer_pkg::OpRestart: begin
        clear_zone();
        budget_left = zone_len;
      end
      default: ;
    endcase
    if (item_syms.size() > 0) item_syms[item_syms.size() - 1].last = 1'b1;
  endfunction

  function automatic row_t cfg_row(input logic [31:0] v);
    row_t rw;
    rw = '0;
    rw.set_cfg = 1'b1;
    rw.cfg = v;
    return rw;
  endfunction

  function automatic row_t op_row(input logic [1:0] op, input logic [7:0] lit,
                                  input logic [5:0] len, input logic [12:0] back_dist,
                                  input int n_typed, input logic [7:0] t_val,
                                  input logic [7:0] t_cnt, input logic t_fin);
    row_t rw;
    rw = '0;
    rw.op = op;
    rw.lit = lit;
    rw.len = len;
    rw.back_dist = back_dist;
    rw.n_typed = n_typed;
    rw.t_val = t_val;
    rw.t_cnt = t_cnt;
    rw.t_fin = t_fin;
    return rw;
  endfunction

  function automatic void add_row(input row_t rw);
    dir_tab.insert(dir_tab.size(), rw);
  endfunction

  function automatic void add_due(input sym_t s);
    decoded_due.insert(decoded_due.size(), s);
  endfunction

  task automatic set_zone_len(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    zone_len = v;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] lit,
                           input logic [5:0] len, input logic [12:0] back_dist,
                           input int n_typed, input logic [7:0] t_val,
                           input logic [7:0] t_cnt, input logic t_fin);
    sym_t s;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    literal_byte_i <= lit;
    copy_length_i <= len;
    copy_distance_i <= back_dist;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expand_item(op, lit, len, back_dist);
    if (n_typed == Predicted) begin
      foreach (item_syms[k]) add_due(item_syms[k]);
    end else if (n_typed == 1) begin
      s.val = t_val;
      s.cnt = t_cnt;
      s.last = 1'b1;
      s.fin = t_fin;
      add_due(s);
    end
    if (op != OpUnused) items_fed++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] lit,
                         input logic [5:0] len, input logic [12:0] back_dist);
    send_item(op, lit, len, back_dist, Predicted, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic random_item();
    logic [31:0] r;
    logic [31:0] q;
    logic [7:0]  b;
    logic [5:0]  n;
    logic [12:0] d;
    int unsigned pick;
    r = $urandom;
    q = $urandom;
    b = r[7:0];
    n = r[13:8];
    d = r[26:14];
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if (r[31:30] == 2'b00) b = r[29] ? wcer_pkg::EscOpen : wcer_pkg::EscRun;
      send_op(wcer_pkg::OpLiteral, b, n, d);
    end else if (pick < 55) begin
      // well-formed escape with random tail
      send_op(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, n, d);
      if (q[0]) begin
        send_op(wcer_pkg::OpLiteral, wcer_pkg::EscRun, q[14:9], q[27:15]);
        send_op(wcer_pkg::OpLiteral, q[1] ? {4'h0, q[5:2]} : q[31:24], n, d);
      end else begin
        send_op(wcer_pkg::OpLiteral, q[8:1], q[14:9], q[27:15]);
      end
    end else if (pick < 88) begin
      if (q[31:29] == 3'b000) n = 6'd63;
      else if (!q[28]) n = {2'b00, q[3:0]};
      if (q[27:26] != 2'b00) d = {7'd0, q[21:16]};
      send_op(wcer_pkg::OpCopy, b, n, d);
    end else if (pick < 95) begin
      send_op(wcer_pkg::OpRestart, b, n, d);
    end else begin
      send_op(OpUnused, b, n, d);
    end
  endtask

  // output stall bursts
  always @(posedge clk_i) begin
    if (calm) begin
      hold_left <= 0;
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    sym_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_due.size() == 0) begin
        $error("out_byte: expected none, actual %0h", out_byte_o);
        fault_count++;
      end else begin
        want = decoded_due.pop_front();
        if (out_byte_o !== want.val) begin
          $error("out_byte: expected %0h, actual %0h", want.val, out_byte_o);
          fault_count++;
        end
        if (repeat_count_o !== want.cnt) begin
          $error("repeat_count: expected %0d, actual %0d", want.cnt, repeat_count_o);
          fault_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          fault_count++;
        end
        if (finished_o !== want.fin) begin
          $error("finished: expected %0b, actual %0b", want.fin, finished_o);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] zl;
    int base;
    int target;
    clear_zone();
    budget_left = '0;
    zone_len = '0;

    // after reset: no budget
    add_row(op_row(wcer_pkg::OpLiteral, 8'h41, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(OpUnused, 8'hFF, 6'd63, 13'd8191, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpRestart, 8'h00, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));
    // full budget
    add_row(cfg_row(32'hFFFF_FFFF));
    add_row(op_row(wcer_pkg::OpRestart, 8'h00, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h00, 6'd0, 13'd0, 1, 8'h00, 8'd1, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'hFF, 6'd0, 13'd0, 1, 8'hFF, 8'd1, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h41, 6'd0, 13'd0, Predicted,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscRun, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h00, 6'd0, 13'd0, Predicted,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscRun, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h05, 6'd0, 13'd0, Predicted,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpCopy, 8'h00, 6'd63, 13'd1, Predicted, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpCopy, 8'h00, 6'd0, 13'd100, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpCopy, 8'h00, 6'd20, 13'd0, Predicted, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpCopy, 8'h00, 6'd63, 13'd8191, Predicted,
                   8'h00, 8'h00, 1'b0));
    // budget of three: oversized run, escape on the final byte, exhausted budget
    add_row(cfg_row(32'd3));
    add_row(op_row(wcer_pkg::OpRestart, 8'h00, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscRun, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h09, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 0,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, Predicted,
                   8'h00, 8'h00, 1'b0));
    add_row(op_row(wcer_pkg::OpLiteral, wcer_pkg::EscOpen, 6'd0, 13'd0, 1,
                   wcer_pkg::EscOpen, 8'd1, 1'b1));
    add_row(op_row(wcer_pkg::OpLiteral, 8'h20, 6'd0, 13'd0, 0, 8'h00, 8'h00, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].set_cfg) begin
        set_zone_len(dir_tab[k].cfg);
      end else begin
        send_item(dir_tab[k].op, dir_tab[k].lit, dir_tab[k].len, dir_tab[k].back_dist,
                  dir_tab[k].n_typed, dir_tab[k].t_val, dir_tab[k].t_cnt, dir_tab[k].t_fin);
      end
    end

    base = items_fed;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: zl = 32'd0;
        1: zl = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 3))
            0: zl = $urandom_range(1, 8);
            1: zl = $urandom_range(20, 300);
            2: zl = $urandom_range(300, 4000);
            default: zl = $urandom;
          endcase
        end
      endcase
      calm = (ph == 8) || ($urandom_range(0, 3) == 0);
      set_zone_len(zl);
      send_op(wcer_pkg::OpRestart, 8'h00, 6'd0, 13'd0);
      target = base + ((ph == 0) ? 15 : 15 + ph * (RandItems - 15) / 8);
      while (items_fed < target) random_item();
    end

    in_valid_i <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/wcer_pkg.sv
src/window_copy_escape_run_expander_unit.sv
verif/tb_window_copy_escape_run_expander_unit.sv
